// File: design/assert_macros.svh
// assertion helpers used by the checker file slm_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SLM_ASSERT(lbl, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define SLM_ASSERT_NEXT(lbl, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// shared types and constants of the sorted list merge block
// ----------------------------------------------------------------------------
package slm_pkg;

	localparam int LIST_CAPACITY = 32;
	localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
	localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam int DATA_W = 32;
	localparam int IN_TDATA_W = 40;

	typedef enum logic [1:0] {
		CMD_PUSH_A = 2'd0,
		CMD_PUSH_B = 2'd1,
		CMD_MERGE  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [DATA_W-1:0]  value;
	} item_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_MERGE = 1'b1
	} state_t;

endpackage

// File: design/slm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_front
// accepts requests, drops unused command codes, queues the rest for the back
// ----------------------------------------------------------------------------
module slm_front import slm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd[1:0], value[33:2], zero pad
	output logic                   q_valid,
	output item_t                  q_item,
	input  logic                   q_pop
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic [1:0]  raw_cmd;
	logic        cmd_ok;
	logic        push;
	logic        pop;

	assign raw_cmd  = s_tdata[1:0];
	assign cmd_ok   = (raw_cmd == CMD_PUSH_A) || (raw_cmd == CMD_PUSH_B)
		|| (raw_cmd == CMD_MERGE);
	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready && cmd_ok;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cmd: cmd_t'(raw_cmd), value: s_tdata[DATA_W+1:2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/slm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_back
// list stores, merge sequencer and output register
// ----------------------------------------------------------------------------
module slm_back import slm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,   // merged_value[31:0]
	output logic               m_tlast
);

	localparam logic [CNT_W-1:0] CAP = CNT_W'(LIST_CAPACITY);

	logic [DATA_W-1:0] list_a_q [LIST_CAPACITY];
	logic [DATA_W-1:0] list_b_q [LIST_CAPACITY];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   ca_q, cb_q;
	logic [CNT_W-1:0]   ia_q, ib_q, ia_d, ib_d;
	logic               eq_q, eq_d;
	logic [DATA_W-1:0]  rd_a_q, rd_b_q;
	logic [IDX_W-1:0]   addr_a, addr_b;
	logic               wr_a, wr_b, start, emit, take_a, res_last;
	logic               a_has, b_has, out_free;
	logic               vld_q, last_q;
	logic [DATA_W-1:0]  data_q;

	assign out_free = !vld_q || m_tready;
	assign a_has    = ia_q < ca_q;
	assign b_has    = ib_q < cb_q;
	assign addr_a   = (ia_d < CAP) ? ia_d[IDX_W-1:0] : '0;
	assign addr_b   = (ib_d < CAP) ? ib_d[IDX_W-1:0] : '0;

	// sequencer outputs
	always_comb begin
		q_pop  = 1'b0;
		wr_a   = 1'b0;
		wr_b   = 1'b0;
		start  = 1'b0;
		emit   = 1'b0;
		take_a = 1'b0;
		ia_d   = ia_q;
		ib_d   = ib_q;
		eq_d   = eq_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.cmd)
						CMD_PUSH_A: wr_a = (ca_q < CAP);
						CMD_PUSH_B: wr_b = (cb_q < CAP);
						CMD_MERGE: begin
							start = (ca_q != '0) || (cb_q != '0);
							ia_d  = '0;
							ib_d  = '0;
							eq_d  = 1'b0;
						end
						default: ;
					endcase
				end
			end
			ST_MERGE: begin
				if (out_free) begin
					emit = 1'b1;
					if (eq_q) begin
						ib_d = ib_q + CNT_W'(1);
						eq_d = 1'b0;
					end else if (a_has && b_has) begin
						if (rd_a_q == rd_b_q) begin
							take_a = 1'b1;
							ia_d   = ia_q + CNT_W'(1);
							eq_d   = 1'b1;
						end else if ($signed(rd_a_q) < $signed(rd_b_q)) begin
							take_a = 1'b1;
							ia_d   = ia_q + CNT_W'(1);
						end else begin
							ib_d = ib_q + CNT_W'(1);
						end
					end else if (a_has) begin
						take_a = 1'b1;
						ia_d   = ia_q + CNT_W'(1);
					end else begin
						ib_d = ib_q + CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
		res_last = emit && (ia_d == ca_q) && (ib_d == cb_q) && !eq_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (res_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// list stores, registered read at the next head
	always_ff @(posedge clk) begin
		if (wr_a) begin
			list_a_q[ca_q[IDX_W-1:0]] <= q_item.value;
		end
		if (wr_b) begin
			list_b_q[cb_q[IDX_W-1:0]] <= q_item.value;
		end
		rd_a_q <= list_a_q[addr_a];
		rd_b_q <= list_b_q[addr_b];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= take_a ? rd_a_q : rd_b_q;
			last_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ca_q    <= '0;
			cb_q    <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			eq_q    <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ia_q    <= ia_d;
			ib_q    <= ib_d;
			eq_q    <= eq_d;
			if (wr_a) begin
				ca_q <= ca_q + CNT_W'(1);
			end
			if (wr_b) begin
				cb_q <= cb_q + CNT_W'(1);
			end
			if (res_last) begin
				ca_q <= '0;
				cb_q <= '0;
			end
			if (emit) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

// File: design/sorted_list_merge.sv
`timescale 1ns / 1ps
// a push is stored in its list when the back takes it from the request queue
// a merge registers both list heads, then its first result in the output register
// one push per cycle while idle, a merge holds the sequencer until its last result
// one element per cycle unless stalled, set by the single read port of each list store
// reset: asynchronous, clears both counts, the request queue and output valid register
// ----------------------------------------------------------------------------
// sorted_list_merge
// two ascending lists loaded by push requests, merged and streamed on request
// ----------------------------------------------------------------------------
module sorted_list_merge import slm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd[1:0], value[33:2], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // merged_value[31:0]
	output logic                   m_tlast
);

	logic   q_valid;
	logic   q_pop;
	item_t  q_item;

	slm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	slm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: design/slm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_checker
// port level checks of the sorted list merge block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slm_checker import slm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd[1:0], value[33:2], zero pad
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [DATA_W-1:0]      m_tdata,   // merged_value[31:0]
	input  logic                   m_tlast
);

	localparam int RUN_W = $clog2(2 * LIST_CAPACITY + 1);

	logic [RUN_W-1:0]  run_q;
	logic [7:0]        merges_q;
	logic              merge_acc;

	assign merge_acc = s_tvalid && s_tready && (s_tdata[1:0] == CMD_MERGE);

	// results in current run, and merge requests seen so far (saturating)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			merges_q <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				run_q <= m_tlast ? '0 : run_q + RUN_W'(1);
			end
			if (merge_acc && (merges_q != 8'hff)) begin
				merges_q <= merges_q + 8'd1;
			end
		end
	end

	`SLM_ASSERT_NEXT(a_out_hold, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	`SLM_ASSERT(a_run_len, arst_n, run_q < RUN_W'(2 * LIST_CAPACITY),
		"merge run longer than both lists")
	`SLM_ASSERT(a_result_cause, arst_n, !m_tvalid || (merges_q != 8'd0),
		"result without merge request")

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sorted list merge block: requests fill the two lists, a merge
// request streams them out, and each result is compared with an in-bench list
// model or a typed plan row's value under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_top;
	import slm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS = 20;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
	} merged_t;

	typedef struct {
		logic [1:0]        cmd;
		logic [DATA_W-1:0] value;
		bit                typed;
		int                exp_n;
		logic [DATA_W-1:0] exp_value;
	} row_t;

	localparam int N_ROWS = 18;

	// typed rows carry the one obvious result (or none), others use the list model
	row_t plan [N_ROWS] = '{
		'{CMD_MERGE,  32'h0000_0000, 1'b1, 0, 32'h0000_0000},
		'{CMD_PUSH_A, 32'h8000_0000, 1'b0, 0, 32'h0000_0000},
		'{CMD_MERGE,  32'hFFFF_FFFF, 1'b1, 1, 32'h8000_0000},
		'{CMD_PUSH_B, 32'h7FFF_FFFF, 1'b0, 0, 32'h0000_0000},
		'{CMD_MERGE,  32'h0000_0000, 1'b1, 1, 32'h7FFF_FFFF},
		'{CMD_UNUSED, 32'h5555_5555, 1'b0, 0, 32'h0000_0000},
		'{CMD_MERGE,  32'hAAAA_AAAA, 1'b1, 0, 32'h0000_0000},
		'{CMD_PUSH_A, 32'hFFFF_FFFF, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_B, 32'hFFFF_FFFF, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_A, 32'h0000_0005, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_B, 32'h0000_0000, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_B, 32'h0000_0007, 1'b0, 0, 32'h0000_0000},
		'{CMD_MERGE,  32'h1234_5678, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_A, 32'h7FFF_FFFF, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_A, 32'h8000_0000, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_B, 32'h8000_0000, 1'b0, 0, 32'h0000_0000},
		'{CMD_PUSH_B, 32'h0000_0003, 1'b0, 0, 32'h0000_0000},
		'{CMD_MERGE,  32'h0000_0000, 1'b0, 0, 32'h0000_0000}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;   // cmd[1:0], value[33:2], zero pad
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;   // merged_value[31:0]
	logic                  m_tlast;

	logic [DATA_W-1:0] first_store [LIST_CAPACITY];
	logic [DATA_W-1:0] second_store [LIST_CAPACITY];
	int first_count;
	int second_count;
	merged_t produced_q[$];
	merged_t pending_merged_q[$];

	int error_count;
	int n_requests;
	int n_merges;
	int n_dropped;
	int n_results;
	int burst_left;
	int stall_left = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	sorted_list_merge i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (error_count < MAX_PRINTS)
			$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// appends one non-final merge element to the model output
	task automatic add_produced(input logic [DATA_W-1:0] v);
		merged_t r;
		r.value = v;
		r.last = 1'b0;
		produced_q.insert(produced_q.size(), r);
	endtask

	// list model: applies one request, leaves any merge output in produced_q
	task automatic lists_step(input logic [1:0] cmd, input logic [DATA_W-1:0] value);
		int ia;
		int ib;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		ia = 0;
		ib = 0;
		produced_q.delete();
		if (cmd == CMD_PUSH_A) begin
			if (first_count < LIST_CAPACITY) begin
				first_store[first_count] = value;
				first_count++;
			end else
				n_dropped++;
		end else if (cmd == CMD_PUSH_B) begin
			if (second_count < LIST_CAPACITY) begin
				second_store[second_count] = value;
				second_count++;
			end else
				n_dropped++;
		end else if (cmd == CMD_MERGE) begin
			n_merges++;
			while (ia < first_count && ib < second_count) begin
				x = first_store[ia];
				y = second_store[ib];
				if (x == y) begin
					add_produced(x);
					add_produced(y);
					ia++;
					ib++;
				end else if ($signed(x) < $signed(y)) begin
					add_produced(x);
					ia++;
				end else begin
					add_produced(y);
					ib++;
				end
			end
			while (ia < first_count) begin
				add_produced(first_store[ia]);
				ia++;
			end
			while (ib < second_count) begin
				add_produced(second_store[ib]);
				ib++;
			end
			if (produced_q.size() > 0)
				produced_q[produced_q.size() - 1].last = 1'b1;
			first_count = 0;
			second_count = 0;
		end
	endtask

	// one request: handshake, model update, then source pacing
	task automatic issue(input logic [1:0] cmd, input logic [DATA_W-1:0] value,
			input bit typed, input int exp_n, input logic [DATA_W-1:0] exp_value);
		int gap;
		merged_t exp_item;
		s_tdata <= {{(IN_TDATA_W - DATA_W - 2){1'b0}}, value, cmd};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		n_requests++;
		lists_step(cmd, value);
		if (typed) begin
			if (exp_n > 0) begin
				exp_item.value = exp_value;
				exp_item.last = 1'b1;
				pending_merged_q.insert(pending_merged_q.size(), exp_item);
			end
		end else begin
			foreach (produced_q[k])
				pending_merged_q.insert(pending_merged_q.size(), produced_q[k]);
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	task automatic make_list(input int n, input bit ordered, input bit narrow,
			output int vals [40]);
		int t;
		int j;
		for (int i = 0; i < 40; i++) begin
			if (narrow)
				vals[i] = int'($urandom_range(0, 8)) - 4;
			else if ($urandom_range(0, 15) == 0)
				vals[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else
				vals[i] = $urandom;
		end
		if (ordered) begin
			for (int i = 1; i < n; i++) begin
				t = vals[i];
				j = i - 1;
				while (j >= 0 && vals[j] > t) begin
					vals[j + 1] = vals[j];
					j--;
				end
				vals[j + 1] = t;
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(16, 80);
		end else
			stall_left <= stall_left - 1;
		stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
		case (stall_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= $urandom_range(0, 1);
			end
			default: begin
				m_tready <= (stall_phase != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		merged_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_merged_q.size() == 0)
				report_mismatch("unexpected result", m_tdata, '0);
			else begin
				want = pending_merged_q.pop_front();
				if (m_tdata !== want.value)
					report_mismatch("merged_value", m_tdata, want.value);
				if (m_tlast !== want.last)
					report_mismatch("last", DATA_W'(m_tlast), DATA_W'(want.last));
			end
		end
	end

	initial begin
		int na;
		int nb;
		int ia;
		int ib;
		int seq;
		int n_counted;
		bit ordered;
		bit narrow;
		int va [40];
		int vb [40];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		first_count = 0;
		second_count = 0;
		error_count = 0;
		n_requests = 0;
		n_merges = 0;
		n_dropped = 0;
		n_results = 0;
		burst_left = 0;
		seq = 0;
		n_counted = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			issue(plan[r].cmd, plan[r].value, plan[r].typed, plan[r].exp_n,
				plan[r].exp_value);

		while (n_counted < RANDOM_ITEMS) begin
			// first sequence overfills both lists
			if (seq == 0) begin
				na = LIST_CAPACITY + 1;
				nb = LIST_CAPACITY + 2;
			end else if ($urandom_range(0, 9) == 0) begin
				na = $urandom_range(LIST_CAPACITY - 4, LIST_CAPACITY + 2);
				nb = $urandom_range(0, LIST_CAPACITY + 2);
			end else begin
				na = $urandom_range(0, 6);
				nb = $urandom_range(0, 6);
			end
			ordered = ($urandom_range(0, 7) != 0);
			narrow = $urandom_range(0, 1);
			make_list(na, ordered, narrow, va);
			make_list(nb, ordered, narrow, vb);
			ia = 0;
			ib = 0;
			while (ia < na || ib < nb) begin
				if ($urandom_range(0, 19) == 0)
					issue(CMD_UNUSED, $urandom, 1'b0, 0, '0);
				if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
					issue(CMD_PUSH_A, va[ia], 1'b0, 0, '0);
					ia++;
				end else begin
					issue(CMD_PUSH_B, vb[ib], 1'b0, 0, '0);
					ib++;
				end
				n_counted++;
			end
			// now and then the lists carry over into the next sequence
			if (seq == 0 || $urandom_range(0, 11) != 0) begin
				issue(CMD_MERGE, $urandom, 1'b0, 0, '0);
				n_counted++;
			end
			seq++;
		end
		issue(CMD_MERGE, $urandom, 1'b0, 0, '0);
		s_tvalid <= 1'b0;

		while (pending_merged_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests, %0d merges, %0d pushes dropped on full lists",
			n_requests, n_merges, n_dropped);
		$display("tb: %0d merged results checked, %0d mismatches", n_results, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
